>>> rtl/ass_pkg.sv
package ass_pkg;

  localparam int BarCountBits = 16;
  localparam int MaxResults = 7;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SYNC      = 3'd1,
    CMD_START     = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_HALF_BAR  = 3'd4,
    CMD_SET_CHORD = 3'd5,
    CMD_REQUEST   = 3'd6,
    CMD_UNUSED    = 3'd7
  } cmd_t;

  localparam logic [1:0] KIND_NOTE_ON = 2'd0;
  localparam logic [1:0] KIND_ALL_OFF = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [4:0] SEC_STOP    = 5'd0;
  localparam logic [4:0] SEC_WAIT    = 5'd1;
  localparam logic [4:0] SEC_INTRO_A = 5'd2;
  localparam logic [4:0] SEC_MAIN_A  = 5'd5;
  localparam logic [4:0] SEC_MAIN_D  = 5'd8;
  localparam logic [4:0] SEC_FILL_AA = 5'd9;
  localparam logic [4:0] SEC_FILL_DD = 5'd12;
  localparam logic [4:0] SEC_BREAK   = 5'd13;
  localparam logic [4:0] SEC_END_A   = 5'd14;
  localparam logic [4:0] SEC_END_C   = 5'd16;

  localparam logic [3:0] CH_DRUM  = 4'd9;
  localparam logic [3:0] CH_BASS  = 4'd10;
  localparam logic [3:0] CH_CHORD = 4'd11;
  localparam logic [3:0] CH_PAD   = 4'd12;

  localparam logic [0:0] REG_TRANSPOSE = 1'd0;
  localparam logic [0:0] REG_OCTAVE    = 1'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        channel;
    logic signed [8:0] note;
    logic [6:0]        velocity;
  } event_t;

  typedef struct packed {
    logic [4:0]  section_now;
    logic [15:0] bar_number;
    logic [2:0]  beat_number;
  } status_t;

  typedef struct packed {
    logic [2:0] count;
    event_t [MaxResults-2:0] events;
    status_t status;
  } batch_t;

endpackage

>>> rtl/ass_in_if.sv
interface ass_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [6:0] chord_root;
  logic       chord_is_minor;
  logic [4:0] wanted_section;

  modport source (output valid, cmd, chord_root, chord_is_minor, wanted_section, input ready);
  modport sink (input valid, cmd, chord_root, chord_is_minor, wanted_section, output ready);
endinterface

>>> rtl/ass_out_if.sv
interface ass_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [3:0]        channel;
  logic signed [8:0] note;
  logic [6:0]        velocity;
  logic [4:0]        section_now;
  logic [15:0]       bar_number;
  logic [2:0]        beat_number;
  logic              last;

  modport source (output valid, kind, channel, note, velocity, section_now, bar_number,
    beat_number, last, input ready);
  modport sink (input valid, kind, channel, note, velocity, section_now, bar_number,
    beat_number, last, output ready);
endinterface

>>> rtl/arranger_section_sequencer_top.sv
// Channel   Dir  Payload
// in        in   cmd, chord_root, chord_is_minor, wanted_section
// res       out  kind, channel, note, velocity, section_now, bar_number,
//                beat_number, last
// cfg       in   cfg_we, cfg_index, cfg_data
// One input transaction is computed combinationally into a result batch of
// one to seven results; the batch register then drains one result per cycle
// while res.ready is high.
// The next input is accepted in the cycle the previous batch's status leaves.
// rst is synchronous and clears state to stopped, bar 1, step 0.
module arranger_section_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  ass_in_if.sink     in,
  ass_out_if.source  res
);

  logic signed [4:0] transpose;
  logic signed [2:0] octave;
  logic [4:0]  section_code;
  logic [3:0]  step;
  logic [ass_pkg::BarCountBits-1:0] bar_count;
  logic [4:0]  pending_section;
  logic        pending_valid;
  logic [6:0]  root_note;
  logic        minor_flag;

  logic [4:0]  section_next;
  logic [3:0]  step_next;
  logic [ass_pkg::BarCountBits-1:0] bar_next;
  logic [4:0]  pending_section_next;
  logic        pending_valid_next;
  logic [6:0]  root_next;
  logic        minor_next;

  ass_pkg::batch_t batch;
  logic            busy;
  logic            free_next;
  logic            accept;

  assign in.ready = free_next;
  assign accept   = in.valid && in.ready;

  // Configuration writes, saturated.
  always_ff @(posedge clk) begin
    if (rst) begin
      transpose <= 5'sd0;
      octave    <= 3'sd0;
    end else if (cfg_we) begin
      if (cfg_index == ass_pkg::REG_TRANSPOSE) begin
        if ($signed(cfg_data) < -5'sd12) transpose <= -5'sd12;
        else if ($signed(cfg_data) > 5'sd12) transpose <= 5'sd12;
        else transpose <= $signed(cfg_data);
      end else begin
        if ($signed(cfg_data[2:0]) < -3'sd2) octave <= -3'sd2;
        else if ($signed(cfg_data[2:0]) > 3'sd2) octave <= 3'sd2;
        else octave <= $signed(cfg_data[2:0]);
      end
    end
  end

  // Per-item combinational work.
  logic signed [8:0] root_adj;
  logic [1:0]        v;
  logic [6:0]        vel_m;
  logic [2:0]        n;
  logic [3:0]        s;
  logic [4:0]        sec;
  logic [4:0]        step_inc;
  logic [4:0]        third;

  always_comb begin
    s   = step;
    sec = section_code;
    root_adj = $signed({2'b00, root_note}) + 9'(transpose) + 9'(octave) * 9'sd12;
    third = minor_flag ? 5'd3 : 5'd4;
    v   = 2'd0;
    vel_m = 7'd0;
    n   = 3'd0;
    batch = '0;
    section_next = section_code;
    step_next    = step;
    bar_next     = bar_count;
    pending_section_next = pending_section;
    pending_valid_next   = pending_valid;
    root_next  = root_note;
    minor_next = minor_flag;
    step_inc   = {1'b0, step} + 5'd1;

    unique case (ass_pkg::cmd_t'(in.cmd))
      ass_pkg::CMD_TICK: begin
        if (sec >= ass_pkg::SEC_INTRO_A && sec <= ass_pkg::SEC_END_C) begin
          if (sec < ass_pkg::SEC_MAIN_A) begin
            v = 2'(sec - ass_pkg::SEC_INTRO_A);
            if (s == 4'd0) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_PAD, root_adj + 9'sd12,
                7'(72 + 4 * v)}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_PAD,
                root_adj + 9'sd12 + 9'(third), 7'(66 + 4 * v)}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_PAD, root_adj + 9'sd19,
                7'(66 + 4 * v)}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd49,
                7'(112 + 4 * v)}; n = n + 3'd1;
            end
            if (s == 4'd4 || s == 4'd12) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd38,
                7'(92 + 4 * v)}; n = n + 3'd1;
            end
            if (s == 4'd8) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd36,
                7'(108 + 4 * v)}; n = n + 3'd1;
            end
            if (!s[0]) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd42,
                7'(66 + 3 * v)}; n = n + 3'd1;
            end
          end else if (sec <= ass_pkg::SEC_MAIN_D) begin
            v = 2'(sec - ass_pkg::SEC_MAIN_A);
            vel_m = 7'(64 + 7 * v);
            if (s == 4'd0 || s == 4'd8) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd36,
                7'(108 + 4 * v)}; n = n + 3'd1;
            end
            if (s == 4'd4 || s == 4'd12) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd38,
                7'(102 + 4 * v)}; n = n + 3'd1;
            end
            if (!s[0]) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM,
                (v >= 2'd2 && s[1:0] == 2'd0) ? 9'sd46 : 9'sd42, 7'(68 + 5 * v)};
              n = n + 3'd1;
            end
            if (v == 2'd3 && (s == 4'd6 || s == 4'd14)) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd47, 7'd92};
              n = n + 3'd1;
            end
            if (s == 4'd0 || s == 4'd8) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_BASS, root_adj - 9'sd24,
                7'd104}; n = n + 3'd1;
            end
            if (v >= 2'd1 && (s == 4'd4 || s == 4'd12)) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_BASS, root_adj - 9'sd17,
                7'd88}; n = n + 3'd1;
            end
            if (v == 2'd3 && (s == 4'd6 || s == 4'd14)) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_BASS, root_adj - 9'sd12,
                7'd82}; n = n + 3'd1;
            end
            if (s[1:0] == 2'd0) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_CHORD, root_adj, vel_m};
              n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_CHORD,
                root_adj + 9'(third), vel_m - 7'd6}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_CHORD,
                root_adj + 9'sd7, vel_m - 7'd6}; n = n + 3'd1;
            end
          end else if (sec <= ass_pkg::SEC_FILL_DD) begin
            v = 2'(sec - ass_pkg::SEC_FILL_AA);
            if (s == 4'd0 || s == 4'd8) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd36, 7'd116};
              n = n + 3'd1;
            end
            if (!s[3]) begin
              if (!s[0]) begin
                batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM,
                  9'sd45 + 9'(v), 7'(98 + 4 * v)}; n = n + 3'd1;
              end
            end else begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM,
                s[0] ? 9'sd50 : 9'sd47, 7'(108 + 3 * v)}; n = n + 3'd1;
              if (s >= 4'd12) begin
                batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd38, 7'd116};
                n = n + 3'd1;
              end
            end
            if (s == 4'd15) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd49, 7'd124};
              n = n + 3'd1;
            end
          end else if (sec == ass_pkg::SEC_BREAK) begin
            if (s == 4'd0) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd49, 7'd120};
              n = n + 3'd1;
            end
            if (s == 4'd8) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd38, 7'd100};
              n = n + 3'd1;
            end
            if (s == 4'd15) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd36, 7'd118};
              n = n + 3'd1;
            end
          end else begin
            v = 2'(sec - ass_pkg::SEC_END_A);
            if (s == 4'd0) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_PAD, root_adj + 9'sd12,
                7'(80 + 4 * v)}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_PAD,
                root_adj + 9'sd12 + 9'(third), 7'(72 + 4 * v)}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_PAD, root_adj + 9'sd19,
                7'(72 + 4 * v)}; n = n + 3'd1;
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd49, 7'd124};
              n = n + 3'd1;
            end
            if (s == 4'd4) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd38,
                7'(104 + 4 * v)}; n = n + 3'd1;
            end
            if (s == 4'd8) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd36, 7'd120};
              n = n + 3'd1;
            end
            if (s == 4'd12) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd41 + 9'(v),
                7'd108}; n = n + 3'd1;
            end
            if (s == 4'd15) begin
              batch.events[n] = '{ass_pkg::KIND_NOTE_ON, ass_pkg::CH_DRUM, 9'sd49, 7'd124};
              n = n + 3'd1;
            end
          end
          // Advance the step; handle the bar boundary.
          step_next = step_inc[3:0];
          if (step_inc[4]) begin
            bar_next = bar_count + 1'b1;
            if (sec < ass_pkg::SEC_MAIN_A || sec == ass_pkg::SEC_BREAK) begin
              batch.events[n] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = n + 3'd1;
              section_next = ass_pkg::SEC_MAIN_A;
            end else if (sec >= ass_pkg::SEC_FILL_AA && sec <= ass_pkg::SEC_FILL_DD) begin
              batch.events[n] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = n + 3'd1;
              section_next = sec - ass_pkg::SEC_FILL_AA + ass_pkg::SEC_MAIN_A;
            end else if (sec >= ass_pkg::SEC_END_A) begin
              batch.events[n] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = n + 3'd1;
              section_next = ass_pkg::SEC_STOP;
              pending_valid_next = 1'b0;
            end else if (pending_valid) begin
              batch.events[n] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = n + 3'd1;
              pending_valid_next = 1'b0;
              section_next = pending_section;
            end
          end
        end
      end
      ass_pkg::CMD_SYNC: begin
        batch.events[0] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = 3'd1;
        step_next = 4'd0; bar_next = ass_pkg::BarCountBits'(1);
        section_next = ass_pkg::SEC_WAIT; pending_valid_next = 1'b0;
      end
      ass_pkg::CMD_START: begin
        batch.events[0] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0};
        batch.events[1] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = 3'd2;
        step_next = 4'd0; bar_next = ass_pkg::BarCountBits'(1);
        section_next = ass_pkg::SEC_MAIN_A;
      end
      ass_pkg::CMD_STOP: begin
        batch.events[0] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = 3'd1;
        section_next = ass_pkg::SEC_STOP; pending_valid_next = 1'b0; step_next = 4'd0;
      end
      ass_pkg::CMD_HALF_BAR: begin
        if (sec != ass_pkg::SEC_STOP && sec != ass_pkg::SEC_WAIT) step_next = 4'd8;
      end
      ass_pkg::CMD_SET_CHORD: begin
        root_next  = in.chord_root;
        minor_next = in.chord_is_minor;
        if (sec == ass_pkg::SEC_WAIT) begin
          batch.events[0] = '{ass_pkg::KIND_ALL_OFF, 4'd0, 9'sd0, 7'd0}; n = 3'd1;
          section_next = ass_pkg::SEC_INTRO_A; step_next = 4'd0;
        end
      end
      ass_pkg::CMD_REQUEST: begin
        if (in.wanted_section >= ass_pkg::SEC_INTRO_A &&
            in.wanted_section <= ass_pkg::SEC_END_C) begin
          pending_section_next = in.wanted_section;
          pending_valid_next   = 1'b1;
        end
      end
      ass_pkg::CMD_UNUSED: begin
      end
      default: begin
      end
    endcase
    // Sections above sixteen never occur, and every branch stays within seven results.
    batch.count = n;
    batch.status.section_now = section_next;
    batch.status.bar_number  = 16'(bar_next);
    batch.status.beat_number = {1'b0, step_next[3:2]} + 3'd1;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      section_code    <= ass_pkg::SEC_STOP;
      step            <= 4'd0;
      bar_count       <= ass_pkg::BarCountBits'(1);
      pending_section <= ass_pkg::SEC_MAIN_A;
      pending_valid   <= 1'b0;
      root_note       <= 7'd0;
      minor_flag      <= 1'b0;
    end else if (accept) begin
      section_code    <= section_next;
      step            <= step_next;
      bar_count       <= bar_next;
      pending_section <= pending_section_next;
      pending_valid   <= pending_valid_next;
      root_note       <= root_next;
      minor_flag      <= minor_next;
    end
  end

  ass_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch     (batch),
    .busy      (busy),
    .free_next (free_next),
    .res       (res)
  );

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    section_code <= ass_pkg::SEC_END_C) else $error("section out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted item left no results");
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (section_code == ass_pkg::SEC_STOP) |-> !(pending_valid && $past(accept) &&
    $past(in.cmd) == ass_pkg::CMD_STOP)) else $error("stop kept a pending request");

endmodule

>>> rtl/ass_drain.sv
// Holds one batch of results and hands them out one per transaction.
module ass_drain (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ass_pkg::batch_t batch,
  output logic            busy,
  output logic            free_next,
  ass_out_if.source       res
);

  ass_pkg::batch_t held;
  logic [2:0]      idx;
  logic            active;
  logic            is_status;
  logic            fire;

  assign busy      = active;
  assign fire      = active && res.ready;
  assign is_status = (idx == held.count);
  // The buffer can take a new batch when empty or when the final result leaves now.
  assign free_next = !active || (fire && is_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (fire) begin
      if (is_status) begin
        active <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= batch;
    end
  end

  // Result mux.
  always_comb begin
    res.valid       = active;
    res.last        = is_status;
    res.kind        = ass_pkg::KIND_STATUS;
    res.channel     = 4'd0;
    res.note        = 9'sd0;
    res.velocity    = 7'd0;
    res.section_now = 5'd0;
    res.bar_number  = 16'd0;
    res.beat_number = 3'd0;
    if (is_status) begin
      res.section_now = held.status.section_now;
      res.bar_number  = held.status.bar_number;
      res.beat_number = held.status.beat_number;
    end else begin
      res.kind     = held.events[idx[2:0] < 3'd6 ? idx : 3'd0].kind;
      res.channel  = held.events[idx[2:0] < 3'd6 ? idx : 3'd0].channel;
      res.note     = held.events[idx[2:0] < 3'd6 ? idx : 3'd0].note;
      res.velocity = held.events[idx[2:0] < 3'd6 ? idx : 3'd0].velocity;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= held.count) else $error("result index past batch end");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free_next) else $error("batch loaded over pending results");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && is_status && !load) |=> !active) else $error("drain did not finish");

endmodule
